>>> hdl/tsb_pkg.sv
package tsb_pkg;

  // field and datapath widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned STEP_W  = MS_W + SCALE_W;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned PER_W   = MS_W + 8;
  localparam int unsigned MASK_W  = 16;

  // time scale after reset: 1.0 in Q8.8
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_RESTART = 2'd3
  } tsb_cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_MUL,
    ST_WALK
  } tsb_state_t;

  // store write enables
  typedef struct packed {
    logic acc_we;
    logic per_we;
  } tsb_wr_t;

  // write-back status from the update unit
  typedef struct packed {
    logic we;
    logic fire;
    logic disarm;
  } tsb_wb_t;

endpackage

>>> hdl/tsb_store.sv
module tsb_store
  import tsb_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  tsb_wr_t          wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ACC_W-1:0] wr_acc,
  input  logic [MS_W-1:0]  wr_per,
  input  logic             wr_loop,
  input  logic [AW-1:0]    rd_addr,
  output logic [ACC_W-1:0] rd_acc,
  output logic [MS_W-1:0]  rd_per,
  output logic             rd_loop
);

  logic [ACC_W-1:0] acc_mem  [DEPTH];
  logic [MS_W-1:0]  per_mem  [DEPTH];
  logic             loop_mem [DEPTH];
  logic [ACC_W-1:0] rd_acc_r;
  logic [MS_W-1:0]  rd_per_r;
  logic             rd_loop_r;

  // accumulator memory
  always_ff @(posedge clk) begin
    if (wr.acc_we) begin
      acc_mem[wr_addr] <= wr_acc;
    end
    rd_acc_r <= acc_mem[rd_addr];
  end

  // period and looping flag memories, written by start only
  always_ff @(posedge clk) begin
    if (wr.per_we) begin
      per_mem[wr_addr]  <= wr_per;
      loop_mem[wr_addr] <= wr_loop;
    end
    rd_per_r  <= per_mem[rd_addr];
    rd_loop_r <= loop_mem[rd_addr];
  end

  assign rd_acc  = rd_acc_r;
  assign rd_per  = rd_per_r;
  assign rd_loop = rd_loop_r;

endmodule

>>> hdl/tsb_update.sv
module tsb_update
  import tsb_pkg::*;
#(
  parameter int unsigned AW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic              in_arm,
  input  logic [AW-1:0]     in_idx,
  input  logic [ACC_W-1:0]  in_acc,
  input  logic [MS_W-1:0]   in_per,
  input  logic              in_loop,
  input  logic [STEP_W-1:0] step,
  output tsb_wb_t           wb,
  output logic [AW-1:0]     wb_idx,
  output logic [ACC_W-1:0]  wb_acc
);

  logic             s_vld_r;
  logic             s_arm_r;
  logic [AW-1:0]    s_idx_r;
  logic [ACC_W-1:0] s_sum_r;
  logic [PER_W-1:0] s_per_r;
  logic             s_loop_r;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] sum_sat;
  logic [ACC_W-1:0] per_ext;
  logic             reached;

  // stage one: saturating add of the scaled step
  always_comb begin
    sum     = {1'b0, in_acc} + (ACC_W + 1)'(step);
    sum_sat = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s_arm_r  <= in_arm;
    s_idx_r  <= in_idx;
    s_sum_r  <= sum_sat;
    s_per_r  <= {in_per, 8'd0};
    s_loop_r <= in_loop;
  end

  // stage two: compare against the period, subtract on a looping fire
  always_comb begin
    per_ext   = ACC_W'(s_per_r);
    reached   = (s_sum_r >= per_ext);
    wb.we     = s_vld_r && s_arm_r;
    wb.fire   = s_vld_r && s_arm_r && reached;
    wb.disarm = s_vld_r && s_arm_r && reached && !s_loop_r;
    wb_idx    = s_idx_r;
    wb_acc    = (reached && s_loop_r) ? (s_sum_r - per_ext) : s_sum_r;
  end

endmodule

>>> hdl/scaled_software_timer_bank.sv
// a command passes the command state and a tick the multiply state and then
// the walk of one shared add/compare unit over the timer memory; busy stays
// high until the result is strobed, and a new item can be taken from the
// cycle its result is strobed on; the receiver cannot stall. synchronous
// active-low reset disarms all timers and sets the time scale to 1.0
module scaled_software_timer_bank
  import tsb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [IDX_W-1:0]   in_timer_index,
  input  logic [MS_W-1:0]    in_period_ms,
  input  logic               in_looping,
  input  logic [MS_W-1:0]    in_elapsed_ms,
  output logic               out_valid,
  output logic [MASK_W-1:0]  out_fired_mask,
  output logic [MASK_W-1:0]  out_armed_mask,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SCALE_W-1:0] cfg_time_scale
);

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 2);

  tsb_state_t          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [SCALE_W-1:0]  scale_r;
  tsb_cmd_t            cmd_r;
  logic [IDX_W-1:0]    idx_r;
  logic [MS_W-1:0]     per_r;
  logic                loop_r;
  logic [MS_W-1:0]     elapsed_r;
  logic [STEP_W-1:0]   step_r;
  logic [NUM_TIMERS-1:0] armed_r, armed_nxt;
  logic [MASK_W-1:0]   fired_r, fired_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]   out_fired_r, out_armed_r;
  logic [MASK_W-1:0]   armed_view;
  logic                p1_vld_r;
  logic                p1_arm_r;
  logic [AW-1:0]       p1_idx_r;
  logic                issue;
  logic                idx_ok;
  logic                accept;
  tsb_wr_t             wr;
  logic [AW-1:0]       wr_addr;
  logic [ACC_W-1:0]    wr_acc;
  logic [ACC_W-1:0]    rd_acc;
  logic [MS_W-1:0]     rd_per;
  logic                rd_loop;
  tsb_wb_t             wb;
  logic [AW-1:0]       wb_idx;
  logic [ACC_W-1:0]    wb_acc;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign idx_ok    = (32'(idx_r) < NUM_TIMERS);
  assign issue     = (state_r == ST_WALK) && (32'(cnt_r) < NUM_TIMERS);

  // time scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_time_scale;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      armed_r     <= '0;
      fired_r     <= '0;
      out_valid_r <= 1'b0;
      p1_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      armed_r     <= armed_nxt;
      fired_r     <= fired_nxt;
      out_valid_r <= out_valid_nxt;
      p1_vld_r    <= issue;
    end
  end

  // command capture, step product and issue-stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= tsb_cmd_t'(in_command);
      idx_r     <= in_timer_index;
      per_r     <= in_period_ms;
      loop_r    <= in_looping;
      elapsed_r <= in_elapsed_ms;
    end
    if (state_r == ST_MUL) begin
      step_r <= elapsed_r * scale_r;
    end
    p1_idx_r <= cnt_r[AW-1:0];
    p1_arm_r <= armed_r[cnt_r[AW-1:0]];
  end

  // armed flags as seen on the 16-bit mask
  always_comb begin
    armed_view = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < NUM_TIMERS) begin
        armed_view[b] = armed_nxt[b];
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_fired_r <= fired_nxt;
      out_armed_r <= armed_view;
    end
  end

  // sequencer: next state, store writes, flag updates
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    armed_nxt     = armed_r;
    fired_nxt     = fired_r;
    out_valid_nxt = 1'b0;
    wr            = '0;
    wr_addr       = wb_idx;
    wr_acc        = wb_acc;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (tsb_cmd_t'(in_command) == CMD_TICK) ? ST_MUL : ST_CMD;
        end
      end
      ST_CMD: begin
        wr_addr = AW'(idx_r);
        wr_acc  = '0;
        if (idx_ok) begin
          unique case (cmd_r)
            CMD_START: begin
              wr.acc_we          = 1'b1;
              wr.per_we          = 1'b1;
              armed_nxt[AW'(idx_r)] = 1'b1;
            end
            CMD_STOP: begin
              armed_nxt[AW'(idx_r)] = 1'b0;
            end
            CMD_RESTART: begin
              wr.acc_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
        fired_nxt     = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_MUL: begin
        cnt_nxt   = '0;
        fired_nxt = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // write back the timer leaving the update unit
        wr.acc_we = wb.we;
        if (wb.disarm) begin
          armed_nxt[wb_idx] = 1'b0;
        end
        for (int b = 0; b < MASK_W; b++) begin
          if (wb.fire && (32'(wb_idx) == b)) begin
            fired_nxt[b] = 1'b1;
          end
        end
        if (32'(cnt_r) == NUM_TIMERS + 1) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  tsb_store #(
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_acc  (wr_acc),
    .wr_per  (per_r),
    .wr_loop (loop_r),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_acc  (rd_acc),
    .rd_per  (rd_per),
    .rd_loop (rd_loop)
  );

  tsb_update #(
    .AW (AW)
  ) u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p1_vld_r),
    .in_arm  (p1_arm_r),
    .in_idx  (p1_idx_r),
    .in_acc  (rd_acc),
    .in_per  (rd_per),
    .in_loop (rd_loop),
    .step    (step_r),
    .wb      (wb),
    .wb_idx  (wb_idx),
    .wb_acc  (wb_acc)
  );

  assign out_valid      = out_valid_r;
  assign out_fired_mask = out_fired_r;
  assign out_armed_mask = out_armed_r;

endmodule

>>> hdl/tsb_checker.sv
module tsb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  // a result closes a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe without preceding busy period");

  // results never come in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

bind scaled_software_timer_bank tsb_checker u_tsb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
